// File: rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the string unescaper: result status codes,
// job kinds and the job record passed from the decoder to the byte emitter.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // status reported on an end-of-string result
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISS_QUOTE = 3'd1,
    ST_BAD_ESC    = 3'd2,
    ST_BAD_HEX    = 3'd3,
    ST_SURROGATE  = 3'd4,
    ST_CTRL       = 3'd5
  } status_e;

  // what the back end does with a job
  typedef enum logic [1:0] {
    KIND_RAW = 2'd0,  // one byte, taken as is
    KIND_CP  = 2'd1,  // code point, sent as one to four utf-8 bytes
    KIND_END = 2'd2   // end of string with status
  } kind_e;

  localparam int unsigned CpWidth = 21;

  typedef struct packed {
    kind_e                kind;
    logic [CpWidth-1:0]   cp;      // raw byte in low bits for KIND_RAW
    status_e              status;
  } job_t;

endpackage

// File: rtl/json_string_unescape_utf8_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Decodes json string bodies byte by byte into utf-8 with end-of-string
// status results.
// ----------------------------------------------------------------------------
// channel   dir  tdata                          tuser    tlast
// s_axis    in   [7:0] in_byte                  -        -
// m_axis    out  [7:0] out_byte [10:8] status   is_end   last of input byte
//
// one input byte per cycle while the job queue has room; each output byte is
// a result of its own, so a \u escape giving four bytes holds the emitter for
// four results. an accepted byte's job goes into the job queue, then from its
// head into the output register, where the result can be taken.
// reset returns the decoder to plain state and empties queue and output.
// a stalled output fills the queue, then drops s_axis_tready.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status
  output logic        m_axis_tuser,   // [0] is_end
  output logic        m_axis_tlast
);

  logic          push, full, pop, empty;
  jsu_pkg::job_t push_job, head;
  logic [7:0]    out_byte;
  logic [2:0]    status;

  // decoder
  jsu_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (s_axis_tvalid),
    .in_ready_i_unused_o (s_axis_tready),
    .in_byte_i           (s_axis_tdata),
    .q_full_i            (full),
    .push_o              (push),
    .job_o               (push_job)
  );

  // job queue
  jsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  // byte emitter
  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .is_end_o     (m_axis_tuser),
    .out_byte_o   (out_byte),
    .status_o     (status),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, status, out_byte};

  // checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("job pushed into full queue");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
    else $error("end result malformed");

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[10:8] == 3'd0)
    else $error("data byte carries status");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");

endmodule

// File: rtl/jsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one input byte per cycle while the job queue has room,
// tracks the escape state and pushes a job for every byte that yields output.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_i_unused_o,
  input  logic [7:0]    in_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jsu_pkg::job_t job_o
);

  // escape phases
  typedef enum logic [5:0] {
    PH_PLAIN   = 6'b000001,
    PH_ESC     = 6'b000010,
    PH_HEX1    = 6'b000100,
    PH_WANT_BS = 6'b001000,
    PH_WANT_U  = 6'b010000,
    PH_HEX2    = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] accum_q, accum_d;
  logic [1:0]  count_q, count_d;
  logic [9:0]  hs_q, hs_d;

  logic        accept;
  logic [4:0]  hex_val;   // bit 4 set for a non-hex byte
  logic [15:0] new_acc;

  assign in_ready_i_unused_o = !q_full_i;
  assign accept = in_valid_i && !q_full_i;

  // hex digit value
  always_comb begin
    hex_val = 5'h10;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = {1'b0, in_byte_i[3:0]};
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_val = {1'b0, in_byte_i[3:0] + 4'd9};
    end
  end

  assign new_acc = {accum_q[11:0], hex_val[3:0]};

  // decode one byte
  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    count_d = count_q;
    hs_d    = hs_q;
    push_o  = 1'b0;
    job_o   = '{kind: jsu_pkg::KIND_RAW, cp: '0, status: jsu_pkg::ST_OK};
    if (accept) begin
      case (phase_q)
        PH_ESC: begin
          phase_d = PH_PLAIN;
          push_o  = 1'b1;
          case (in_byte_i)
            8'h6E: job_o.cp = 21'h0A;   // n
            8'h74: job_o.cp = 21'h09;   // t
            8'h62: job_o.cp = 21'h08;   // b
            8'h66: job_o.cp = 21'h0C;   // f
            8'h76: job_o.cp = 21'h0B;   // v
            8'h72: job_o.cp = 21'h0D;   // r
            8'h5C: job_o.cp = 21'h5C;   // backslash
            8'h2F: job_o.cp = 21'h2F;   // slash
            8'h22: job_o.cp = 21'h22;   // quote
            8'h75: begin                // u
              push_o  = 1'b0;
              phase_d = PH_HEX1;
              accum_d = '0;
              count_d = '0;
            end
            default: begin
              job_o.kind   = jsu_pkg::KIND_END;
              job_o.status = jsu_pkg::ST_BAD_ESC;
              accum_d      = '0;
              count_d      = '0;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (hex_val[4]) begin
            phase_d      = PH_PLAIN;
            accum_d      = '0;
            count_d      = '0;
            push_o       = 1'b1;
            job_o.kind   = jsu_pkg::KIND_END;
            job_o.status = jsu_pkg::ST_BAD_HEX;
          end else if (count_q != 2'd3) begin
            accum_d = new_acc;
            count_d = count_q + 2'd1;
          end else begin
            accum_d = '0;
            count_d = '0;
            if (phase_q == PH_HEX1) begin
              if (new_acc[15:10] == 6'b110110) begin
                hs_d    = new_acc[9:0];
                phase_d = PH_WANT_BS;
              end else begin
                phase_d    = PH_PLAIN;
                push_o     = 1'b1;
                job_o.kind = jsu_pkg::KIND_CP;
                job_o.cp   = {5'b0, new_acc};
              end
            end else begin
              phase_d = PH_PLAIN;
              push_o  = 1'b1;
              if (new_acc[15:10] != 6'b110111) begin
                job_o.kind   = jsu_pkg::KIND_END;
                job_o.status = jsu_pkg::ST_SURROGATE;
              end else begin
                job_o.kind = jsu_pkg::KIND_CP;
                job_o.cp   = {1'b0, hs_q, new_acc[9:0]} + 21'h10000;
              end
            end
          end
        end
        PH_WANT_BS, PH_WANT_U: begin
          if ((phase_q == PH_WANT_BS && in_byte_i != 8'h5C) ||
              (phase_q == PH_WANT_U && in_byte_i != 8'h75)) begin
            phase_d      = PH_PLAIN;
            accum_d      = '0;
            count_d      = '0;
            push_o       = 1'b1;
            job_o.kind   = jsu_pkg::KIND_END;
            job_o.status = jsu_pkg::ST_SURROGATE;
          end else if (phase_q == PH_WANT_BS) begin
            phase_d = PH_WANT_U;
          end else begin
            phase_d = PH_HEX2;
            accum_d = '0;
            count_d = '0;
          end
        end
        default: begin
          phase_d = PH_PLAIN;
          if (in_byte_i == 8'h5C) begin
            phase_d = PH_ESC;
          end else begin
            push_o   = 1'b1;
            job_o.cp = {13'b0, in_byte_i};
            if (in_byte_i == 8'h22 || in_byte_i < 8'h20) begin
              accum_d      = '0;
              count_d      = '0;
              job_o.kind   = jsu_pkg::KIND_END;
              job_o.cp     = '0;
              if (in_byte_i == 8'h22) begin
                job_o.status = jsu_pkg::ST_OK;
              end else if (in_byte_i == 8'h00) begin
                job_o.status = jsu_pkg::ST_MISS_QUOTE;
              end else begin
                job_o.status = jsu_pkg::ST_CTRL;
              end
            end
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      accum_q <= '0;
      count_q <= '0;
      hs_q    <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      count_q <= count_d;
      hs_q    <= hs_d;
    end
  end

endmodule

// File: rtl/jsu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo
// Short job queue between decoder and byte emitter, head shown directly.
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jsu_pkg::job_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  jsu_pkg::job_t        mem_q [DEPTH];
  logic [PtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

// File: rtl/jsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Byte emitter: expands each job into its output bytes and puts them into an
// output register, one per cycle while that register is empty or being taken.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  jsu_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          is_end_o,
  output logic [7:0]    out_byte_o,
  output logic [2:0]    status_o,
  output logic          last_o
);

  logic       valid_q, valid_d;
  logic       is_end_q;
  logic [7:0] byte_q;
  logic [2:0] status_q;
  logic       last_q;
  logic [1:0] idx_q, idx_d;

  logic       load;
  logic [1:0] nm1;       // byte count minus one
  logic [7:0] sel_byte;
  logic       sel_last;
  logic [20:0] cp;

  assign cp = head_i.cp;

  // byte count of the head job
  always_comb begin
    nm1 = 2'd0;
    if (head_i.kind == jsu_pkg::KIND_CP) begin
      if (cp <= 21'h7F) begin
        nm1 = 2'd0;
      end else if (cp <= 21'h7FF) begin
        nm1 = 2'd1;
      end else if (cp <= 21'hFFFF) begin
        nm1 = 2'd2;
      end else begin
        nm1 = 2'd3;
      end
    end
  end

  // pick the byte at the current position
  always_comb begin
    sel_byte = 8'h80 | {2'b0, cp[5:0]};
    case ({nm1, idx_q})
      4'b0000: sel_byte = cp[7:0];
      4'b0100: sel_byte = 8'hC0 | {3'b0, cp[10:6]};
      4'b1000: sel_byte = 8'hE0 | {4'b0, cp[15:12]};
      4'b1001: sel_byte = 8'h80 | {2'b0, cp[11:6]};
      4'b1100: sel_byte = 8'hF0 | {5'b0, cp[20:18]};
      4'b1101: sel_byte = 8'h80 | {2'b0, cp[17:12]};
      4'b1110: sel_byte = 8'h80 | {2'b0, cp[11:6]};
      default: sel_byte = 8'h80 | {2'b0, cp[5:0]};
    endcase
    if (head_i.kind == jsu_pkg::KIND_END) begin
      sel_byte = 8'h00;
    end
  end

  assign sel_last = (idx_q == nm1);
  assign load     = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o    = load && sel_last;

  // control
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      idx_d   = sel_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      is_end_q <= (head_i.kind == jsu_pkg::KIND_END);
      byte_q   <= sel_byte;
      status_q <= (head_i.kind == jsu_pkg::KIND_END) ? head_i.status : jsu_pkg::ST_OK;
      last_q   <= sel_last;
    end
  end

  assign out_valid_o = valid_q;
  assign is_end_o    = is_end_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule
